// ===== rtl/adamax_pkg.sv =====
// Shared types and constants for the Adamax moment update block.
// No dependencies.
`timescale 1ns / 1ps

package adamax_pkg;

   typedef struct packed {
      logic [1:0]         table_select;
      logic [7:0]         first_index;
      logic [5:0]         second_index;
      logic signed [31:0] gradient;
   } req_type;

   typedef struct packed {
      logic signed [31:0] delta;
      logic               saturated;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ADDR, S_READ, S_MUL, S_MOM, S_PROD, S_CHK, S_DIV, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      PW_IDLE, PW_ODD, PW_SQR
   } pw_state_type;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_DECAY    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_DECAY   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STABILITY_TERM = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_NUMBER    = 3'd4;

   localparam logic [1:0] TBL_HIDDEN_BIAS   = 2'd0;
   localparam logic [1:0] TBL_OUTPUT_BIAS   = 2'd1;
   localparam logic [1:0] TBL_INPUT_HIDDEN  = 2'd2;
   localparam logic [1:0] TBL_HIDDEN_OUTPUT = 2'd3;

   localparam logic [15:0] FIRST_DECAY_RESET    = 16'd58982;
   localparam logic [15:0] SECOND_DECAY_RESET   = 16'd65470;
   localparam logic [23:0] STEP_SIZE_RESET      = 24'd33554;
   localparam logic [23:0] STABILITY_TERM_RESET = 24'd1;
   localparam logic [15:0] STEP_NUMBER_RESET    = 16'd1;

   localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
   localparam int          DIV_STEPS = 33;

endpackage

// ===== rtl/adamax_moment_update.sv =====
// Adamax moment update: moment memories, bias-correction sequencer and divider.
// Depends on adamax_pkg.
`timescale 1ns / 1ps

// Usage
//   req_*: one word per parameter update (table, two indices, Q8.24 gradient),
//          accepted when req_valid is high and req_stall is low.
//   rsp_*: one word per request (saturated Q8.24 delta and clip flag), taken
//          when rsp_valid is high and rsp_stall is low.
//   csr_*: register writes (index, data) taken when csr_valid and csr_ready.
// Timing
//   A request passes through address, memory read, moment multiply,
//   write-back, delta multiply, range check and 33 radix-2 steps of the
//   restoring divider, which sets the rate, on its way to rsp_valid. One
//   request is worked on at a time; the next waits until the last is done.
//   A write of first_decay or step_number starts a square-and-multiply pass;
//   csr_ready and the request side hold off until done.
// Reset
//   Reset restores the register defaults and runs a clearing pass over both
//   moment memories, one entry a cycle (STORE_DEPTH entries, 17488 at the
//   default sizes), while req_stall stays high.
// Stall
//   A finished result waits in the output register; the next request is
//   accepted meanwhile and only its final step waits for the register.
module adamax_moment_update #(
   parameter int INPUT_COUNT  = 256,
   parameter int HIDDEN_COUNT = 64,
   parameter int OUTPUT_COUNT = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  adamax_pkg::req_type                 req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output adamax_pkg::rsp_type                 rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [adamax_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                         csr_data
);
   import adamax_pkg::*;

   localparam int STORE_DEPTH = HIDDEN_COUNT + OUTPUT_COUNT + INPUT_COUNT * HIDDEN_COUNT
                                + HIDDEN_COUNT * OUTPUT_COUNT;
   localparam int ADDR_W = $clog2(STORE_DEPTH);

   function automatic logic [7:0] reduce_index(input logic [7:0] val, input int n);
      logic [20:0] r;
      int          k;
      r = {13'b0, val};
      for (k = 7; k >= 0; k--) begin
         if (r >= 21'(n << k)) r = r - 21'(n << k);
      end
      return r[7:0];
   endfunction

   // configuration
   logic [15:0] first_decay_ff, second_decay_ff, step_number_ff;
   logic [23:0] step_size_ff, stability_term_ff;
   logic        pw_start_ff;
   logic        csr_fire;

   // bias correction sequencer
   pw_state_type pw_state_ff;
   logic [30:0]  pw_ff, base_ff, bc_ff;
   logic [15:0]  t_ff;
   logic [30:0]  pw_op_a;
   logic [61:0]  pw_prod;
   logic [30:0]  pw_round;
   logic         pw_busy;

   // item sequencer
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, addr_ff, addr_in;
   req_type            req_ff;
   logic [31:0]        m_mem [STORE_DEPTH];
   logic [31:0]        v_mem [STORE_DEPTH];
   logic [31:0]        m_rd_ff, v_rd_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wa;
   logic [31:0]        m_wd, v_wd;
   logic signed [48:0] fm_prod_ff;
   logic signed [49:0] fg_prod_ff;
   logic [47:0]        v_prod_ff;
   logic signed [50:0] m_sum;
   logic [31:0]        m_new, v_dec, abs_g, v_new, mag;
   logic [31:0]        mag_ff, v_new_ff;
   logic               neg_ff;
   logic [55:0]        p_ff;
   logic [63:0]        den_ff;
   logic [23:0]        eps;
   logic [63:0]        r_ff;
   logic [64:0]        r_shift;
   logic [32:0]        dsh_ff, q_ff;
   logic               ovf_ff;
   logic [5:0]         cnt_ff;
   logic [7:0]         ha, oa, ia, hb, ob;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic               out_load;
   logic [32:0]        clip;
   logic               sat;

   assign csr_ready = !pw_busy && !pw_start_ff;
   assign csr_fire  = csr_valid && csr_ready;
   assign pw_busy   = (pw_state_ff != PW_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         first_decay_ff    <= FIRST_DECAY_RESET;
         second_decay_ff   <= SECOND_DECAY_RESET;
         step_size_ff      <= STEP_SIZE_RESET;
         stability_term_ff <= STABILITY_TERM_RESET;
         step_number_ff    <= STEP_NUMBER_RESET;
         pw_start_ff       <= 1'b1;
      end else begin
         if (pw_start_ff) pw_start_ff <= 1'b0;
         if (csr_fire) begin
            case (csr_index)
               CSR_FIRST_DECAY: begin
                  first_decay_ff <= csr_data[15:0];
                  pw_start_ff    <= 1'b1;
               end
               CSR_SECOND_DECAY:   second_decay_ff   <= csr_data[15:0];
               CSR_STEP_SIZE:      step_size_ff      <= csr_data[23:0];
               CSR_STABILITY_TERM: stability_term_ff <= csr_data[23:0];
               CSR_STEP_NUMBER: begin
                  step_number_ff <= csr_data[15:0];
                  pw_start_ff    <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // beta1^t by square-and-multiply, one product a cycle
   assign pw_op_a  = (pw_state_ff == PW_ODD) ? pw_ff : base_ff;
   assign pw_prod  = pw_op_a * base_ff;
   assign pw_round = 31'((pw_prod + 62'(1 << 29)) >> 30);

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_state_ff <= PW_IDLE;
      end else begin
         case (pw_state_ff)
            PW_IDLE: begin
               if (pw_start_ff) begin
                  base_ff     <= {1'b0, first_decay_ff, 14'b0};
                  pw_ff       <= Q30_ONE;
                  t_ff        <= (step_number_ff == 16'd0) ? 16'd1 : step_number_ff;
                  pw_state_ff <= PW_ODD;
               end
            end
            PW_ODD: begin
               if (t_ff[0]) pw_ff <= pw_round;
               pw_state_ff <= PW_SQR;
            end
            PW_SQR: begin
               base_ff <= pw_round;
               t_ff    <= t_ff >> 1;
               if (t_ff[15:1] == 15'd0) begin
                  bc_ff       <= Q30_ONE - pw_ff;
                  pw_state_ff <= PW_IDLE;
               end else begin
                  pw_state_ff <= PW_ODD;
               end
            end
            default: pw_state_ff <= PW_IDLE;
         endcase
      end
   end

   // address
   always_comb begin
      ha = reduce_index(req_ff.first_index, HIDDEN_COUNT);
      oa = reduce_index(req_ff.first_index, OUTPUT_COUNT);
      ia = reduce_index(req_ff.first_index, INPUT_COUNT);
      hb = reduce_index({2'b0, req_ff.second_index}, HIDDEN_COUNT);
      ob = reduce_index({2'b0, req_ff.second_index}, OUTPUT_COUNT);
      case (req_ff.table_select)
         TBL_HIDDEN_BIAS:  addr_in = ADDR_W'(ha);
         TBL_OUTPUT_BIAS:  addr_in = ADDR_W'(HIDDEN_COUNT) + ADDR_W'(oa);
         TBL_INPUT_HIDDEN: addr_in = ADDR_W'(HIDDEN_COUNT + OUTPUT_COUNT)
                                     + ADDR_W'(ia) * ADDR_W'(HIDDEN_COUNT) + ADDR_W'(hb);
         default:          addr_in = ADDR_W'(HIDDEN_COUNT + OUTPUT_COUNT
                                     + INPUT_COUNT * HIDDEN_COUNT)
                                     + ADDR_W'(ha) * ADDR_W'(OUTPUT_COUNT) + ADDR_W'(ob);
      endcase
   end

   // moment arithmetic
   assign m_sum = 51'(fm_prod_ff) + 51'(fg_prod_ff) + 51'sd32768;
   assign m_new = m_sum[47:16];
   assign v_dec = v_prod_ff[47:16];
   assign abs_g = req_ff.gradient[31] ? 32'(-req_ff.gradient) : 32'(req_ff.gradient);
   assign v_new = (v_dec > abs_g) ? v_dec : abs_g;
   assign mag   = m_new[31] ? 32'(-m_new) : m_new;
   assign eps   = (stability_term_ff == 24'd0) ? 24'd1 : stability_term_ff;

   assign mem_we = (state_ff == S_CLEAR) || (state_ff == S_MOM);
   assign mem_wa = (state_ff == S_CLEAR) ? clr_addr_ff : addr_ff;
   assign m_wd   = (state_ff == S_CLEAR) ? 32'd0 : m_new;
   assign v_wd   = (state_ff == S_CLEAR) ? 32'd0 : v_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         m_mem[mem_wa] <= m_wd;
         v_mem[mem_wa] <= v_wd;
      end
      m_rd_ff <= m_mem[addr_ff];
      v_rd_ff <= v_mem[addr_ff];
   end

   assign r_shift = {r_ff, dsh_ff[32]};
   assign clip    = ovf_ff ? 33'h1_0000_0000 : q_ff;
   assign sat     = ovf_ff || (neg_ff ? (q_ff > 33'h0_8000_0000) : (q_ff > 33'h0_7FFF_FFFF));
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      case (state_ff)
         S_CLEAR: if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) state_in = S_IDLE;
         S_IDLE: begin
            req_stall = pw_busy || pw_start_ff;
            if (req_valid && !req_stall) state_in = S_ADDR;
         end
         S_ADDR: state_in = S_READ;
         S_READ: state_in = S_MUL;
         S_MUL:  state_in = S_MOM;
         S_MOM:  state_in = S_PROD;
         S_PROD: state_in = S_CHK;
         S_CHK:  state_in = S_DIV;
         S_DIV:  if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = S_OUT;
         S_OUT:  if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: req_ff <= req_word;
         S_ADDR: addr_ff <= addr_in;
         S_MUL: begin
            fm_prod_ff <= $signed({1'b0, first_decay_ff}) * $signed(m_rd_ff);
            fg_prod_ff <= $signed({1'b0, 17'd65536 - {1'b0, first_decay_ff}})
                          * req_ff.gradient;
            v_prod_ff  <= second_decay_ff * v_rd_ff;
         end
         S_MOM: begin
            mag_ff   <= mag;
            neg_ff   <= m_new[31];
            v_new_ff <= v_new;
         end
         S_PROD: begin
            p_ff   <= step_size_ff * mag_ff;
            den_ff <= bc_ff * ({1'b0, v_new_ff} + 33'(eps));
         end
         S_CHK: begin
            // quotient of 2^33 or more clips regardless of sign
            ovf_ff <= ({11'b0, p_ff[55:3]} >= den_ff);
            r_ff   <= {11'b0, p_ff[55:3]};
            dsh_ff <= {p_ff[2:0], 30'b0};
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         S_DIV: begin
            if (r_shift >= {1'b0, den_ff}) begin
               r_ff <= 64'(r_shift - {1'b0, den_ff});
               q_ff <= {q_ff[31:0], 1'b1};
            end else begin
               r_ff <= r_shift[63:0];
               q_ff <= {q_ff[31:0], 1'b0};
            end
            dsh_ff <= dsh_ff << 1;
            cnt_ff <= cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (neg_ff) begin
            rsp_ff.delta <= sat ? 32'sh8000_0000 : 32'(-q_ff[31:0]);
         end else begin
            rsp_ff.delta <= sat ? 32'sh7FFF_FFFF : clip[31:0];
         end
         rsp_ff.saturated <= sat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_no_recompute_in_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOM || state_ff == S_DIV) |-> !pw_busy)
      else $error("bias correction recompute overlaps an item");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && !ovf_ff) |-> (r_ff < den_ff))
      else $error("divider remainder out of range");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (state_ff == S_CLEAR && clr_addr_ff == '0))
      else $error("clearing pass not started after reset");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for adamax_moment_update: directed table, then random phases.
// Depends on adamax_pkg and the adamax_moment_update RTL.
`timescale 1ns / 1ps

module tb;
   import adamax_pkg::*;

   localparam int INPUT_COUNT  = 256;
   localparam int HIDDEN_COUNT = 64;
   localparam int OUTPUT_COUNT = 16;
   localparam int STORE_DEPTH  = HIDDEN_COUNT + OUTPUT_COUNT + INPUT_COUNT * HIDDEN_COUNT
                                 + HIDDEN_COUNT * OUTPUT_COUNT;
   localparam int IDLE_LIMIT   = 60000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 215;

   typedef struct {
      int      phase;
      req_type word;
      bit      fixed;
      rsp_type result;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // mirror of the block state
   logic [31:0] first_mom [STORE_DEPTH];
   logic [31:0] second_mom [STORE_DEPTH];
   longint unsigned beta1, beta2, alpha, eps_reg, step_reg, correction;

   rsp_type pending_deltas[$];
   bit      fixed_next[$];
   rsp_type fixed_vals[$];
   int      errors = 0;
   int      checked = 0;
   int      idle_count = 0;
   bit      hold_request = 1'b0;
   bit      send_burst = 1'b0;
   row_type rows[$];

   adamax_moment_update #(
      .INPUT_COUNT(INPUT_COUNT), .HIDDEN_COUNT(HIDDEN_COUNT), .OUTPUT_COUNT(OUTPUT_COUNT)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   function automatic longint unsigned round_q30(longint unsigned x, longint unsigned y);
      return (x * y + (64'd1 << 29)) >> 30;
   endfunction

   function automatic void recompute_correction();
      longint unsigned base, pw, t;
      base = beta1 << 14;
      pw = 64'd1 << 30;
      t = (step_reg == 0) ? 1 : step_reg;
      while (t != 0) begin
         if (t[0]) pw = round_q30(pw, base);
         base = round_q30(base, base);
         t = t >> 1;
      end
      correction = (64'd1 << 30) - pw;
   endfunction

   function automatic int moment_addr(req_type w);
      int a, b;
      a = w.first_index;
      b = w.second_index;
      case (w.table_select)
         TBL_HIDDEN_BIAS:  return a % HIDDEN_COUNT;
         TBL_OUTPUT_BIAS:  return HIDDEN_COUNT + a % OUTPUT_COUNT;
         TBL_INPUT_HIDDEN: return HIDDEN_COUNT + OUTPUT_COUNT
                                  + (a % INPUT_COUNT) * HIDDEN_COUNT + b % HIDDEN_COUNT;
         default:          return HIDDEN_COUNT + OUTPUT_COUNT + INPUT_COUNT * HIDDEN_COUNT
                                  + (a % HIDDEN_COUNT) * OUTPUT_COUNT + b % OUTPUT_COUNT;
      endcase
   endfunction

   // update both moments of the addressed parameter and return its delta
   function automatic rsp_type update_moments(req_type w);
      int addr;
      longint signed g, m, s, mn;
      longint unsigned absg, vd, vn, eps, den, mag, p;
      logic [127:0] quo;
      logic [63:0] res;
      rsp_type r;
      addr = moment_addr(w);
      g = longint'(w.gradient);
      m = longint'($signed(first_mom[addr]));
      s = longint'(beta1) * m + longint'(65536 - beta1) * g;
      mn = (s + 32768) >>> 16;
      first_mom[addr] = mn[31:0];
      absg = (g < 0) ? -g : g;
      vd = (beta2 * longint'(second_mom[addr])) >> 16;
      vn = (vd > absg) ? vd : absg;
      second_mom[addr] = vn[31:0];
      eps = (eps_reg == 0) ? 1 : eps_reg;
      den = correction * ({32'd0, vn[31:0]} + eps);
      mag = (mn < 0) ? -mn : mn;
      p = alpha * mag;
      quo = ({64'd0, p} << 30) / {64'd0, den};
      if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
      r.saturated = 1'b0;
      if (mn < 0) begin
         if (quo > (128'd1 << 31)) begin
            quo = 128'd1 << 31;
            r.saturated = 1'b1;
         end
         res = 64'd0 - quo[63:0];
      end else begin
         if (quo > 128'h7FFF_FFFF) begin
            quo = 128'h7FFF_FFFF;
            r.saturated = 1'b1;
         end
         res = quo[63:0];
      end
      r.delta = res[31:0];
      return r;
   endfunction

   // scoreboard: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      rsp_type want, pred;
      bit busy;
      busy = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            busy = 1'b1;
            case (csr_index)
               CSR_FIRST_DECAY:    begin beta1 = csr_data[15:0]; recompute_correction(); end
               CSR_SECOND_DECAY:   beta2 = csr_data[15:0];
               CSR_STEP_SIZE:      alpha = csr_data[23:0];
               CSR_STABILITY_TERM: eps_reg = csr_data[23:0];
               CSR_STEP_NUMBER:    begin step_reg = csr_data[15:0]; recompute_correction(); end
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            busy = 1'b1;
            pred = update_moments(req_word);
            if (fixed_next.size() != 0 && fixed_next.pop_front())
               pending_deltas.push_back(fixed_vals.pop_front());
            else
               pending_deltas.push_back(pred);
         end
         if (rsp_valid && !rsp_stall) begin
            busy = 1'b1;
            checked++;
            if (pending_deltas.size() == 0) begin
               $display("%0t: result with nothing expected: delta %h sat %b",
                        $time, rsp_word.delta, rsp_word.saturated);
               errors++;
            end else begin
               want = pending_deltas.pop_front();
               if (rsp_word.delta !== want.delta) begin
                  $display("%0t: delta expected %h actual %h", $time, want.delta, rsp_word.delta);
                  errors++;
               end
               if (rsp_word.saturated !== want.saturated) begin
                  $display("%0t: saturated expected %b actual %b",
                           $time, want.saturated, rsp_word.saturated);
                  errors++;
               end
            end
         end
      end
      idle_count = busy ? 0 : idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stall per word, bursts without stall, one long hold-off
   initial begin
      int n, count;
      bit quiet;
      count = 0;
      quiet = 1'b0;
      forever begin
         if (count % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
         count++;
         if (hold_request) begin
            n = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            n = quiet ? 0 : $urandom_range(0, 19);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_word(req_type w);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      // let the scoreboard log the last accepted word first
      @(posedge clock);
      while (pending_deltas.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all five registers plus one unknown index; hold valid between words
   task automatic write_settings(logic [15:0] b1, logic [15:0] b2, logic [23:0] a,
                                 logic [23:0] e, logic [15:0] t);
      logic [31:0] vals [6];
      logic [CSR_INDEX_W-1:0] idx [6];
      idx[0] = CSR_FIRST_DECAY;    vals[0] = {16'($urandom_range(0, 65535)), b1};
      idx[1] = CSR_SECOND_DECAY;   vals[1] = {16'($urandom_range(0, 65535)), b2};
      idx[2] = CSR_STEP_SIZE;      vals[2] = {8'($urandom_range(0, 255)), a};
      idx[3] = CSR_STABILITY_TERM; vals[3] = {8'($urandom_range(0, 255)), e};
      idx[4] = CSR_STEP_NUMBER;    vals[4] = {16'($urandom_range(0, 65535)), t};
      idx[5] = CSR_INDEX_W'($urandom_range(CSR_STEP_NUMBER + 1, (1 << CSR_INDEX_W) - 1));
      vals[5] = $urandom;
      for (int i = 0; i < 6; i++) begin
         csr_index <= idx[i];
         csr_data <= vals[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic void add_row(int phase, logic [1:0] tbl, logic [7:0] i1, logic [5:0] i2,
                                   logic [31:0] g, bit fixed, logic [31:0] d, bit sat);
      row_type r;
      r.phase = phase;
      r.word = {tbl, i1, i2, g};
      r.fixed = fixed;
      r.result = {d, sat};
      rows.push_back(r);
   endfunction

   function automatic logic [31:0] pick_gradient();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
         2: case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               3: return 32'h1;
               default: return 32'hFFFF_FFFF;
            endcase
         3: return 32'($signed($urandom_range(0, 67108864)) - 33554432);
         4: return 32'h0;
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [23:0] pick24(logic [23:0] lo);
      case ($urandom_range(0, 3))
         0: return lo;
         1: return 24'hFF_FFFF;
         2: return 24'($urandom_range(0, 65535));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 3))
         0: return 16'h0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(50000, 65535));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      req_type pool [8];
      req_type w;
      int phase;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         first_mom[i] = '0;
         second_mom[i] = '0;
      end
      beta1 = FIRST_DECAY_RESET;
      beta2 = SECOND_DECAY_RESET;
      alpha = STEP_SIZE_RESET;
      eps_reg = STABILITY_TERM_RESET;
      step_reg = STEP_NUMBER_RESET;
      recompute_correction();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: a fresh entry with zero gradient gives zero
      add_row(0, TBL_HIDDEN_BIAS, 8'd0, 6'd0, 32'h0, 1, 32'h0, 0);
      add_row(0, TBL_OUTPUT_BIAS, 8'd255, 6'd0, 32'h7FFF_FFFF, 0, 0, 0);
      add_row(0, TBL_INPUT_HIDDEN, 8'd255, 6'd63, 32'h8000_0000, 0, 0, 0);
      add_row(0, TBL_HIDDEN_OUTPUT, 8'd255, 6'd63, 32'h1, 0, 0, 0);
      add_row(0, TBL_INPUT_HIDDEN, 8'd0, 6'd0, 32'hFFFF_FFFF, 0, 0, 0);
      // slow first decay, no second decay: a large then zero gradient clips both ways
      add_row(1, TBL_HIDDEN_BIAS, 8'd5, 6'd0, 32'h7FFF_FFFF, 0, 0, 0);
      add_row(1, TBL_HIDDEN_BIAS, 8'd5, 6'd0, 32'h0, 1, 32'h7FFF_FFFF, 1);
      add_row(1, TBL_OUTPUT_BIAS, 8'd3, 6'd0, 32'h8000_0000, 0, 0, 0);
      add_row(1, TBL_OUTPUT_BIAS, 8'd3, 6'd0, 32'h0, 1, 32'h8000_0000, 1);
      add_row(1, TBL_INPUT_HIDDEN, 8'd0, 6'd0, 32'h7FFF_FFFF, 0, 0, 0);
      // zero step size always gives zero
      add_row(2, TBL_HIDDEN_OUTPUT, 8'd7, 6'd9, 32'h1234_5678, 1, 32'h0, 0);
      add_row(2, TBL_INPUT_HIDDEN, 8'd100, 6'd20, 32'hFFFF_FFFB, 1, 32'h0, 0);
      // zero step number and zero stability term, indices past table ends
      add_row(3, TBL_HIDDEN_BIAS, 8'd70, 6'd0, 32'h0100_0000, 0, 0, 0);
      add_row(3, TBL_OUTPUT_BIAS, 8'd20, 6'd33, 32'hFF00_0000, 0, 0, 0);
      add_row(3, TBL_HIDDEN_OUTPUT, 8'd64, 6'd17, 32'h0000_8000, 0, 0, 0);
      add_row(3, TBL_INPUT_HIDDEN, 8'd3, 6'd4, 32'h0, 0, 0, 0);

      phase = 0;
      foreach (rows[i]) begin
         if (rows[i].phase != phase) begin
            phase = rows[i].phase;
            wait_drained();
            case (phase)
               1: write_settings(16'hFFFF, 16'h0, 24'hFF_FFFF, 24'h1, 16'd1);
               2: write_settings(16'h0, 16'hFFFF, 24'h0, 24'hFF_FFFF, 16'hFFFF);
               default: write_settings(16'h8000, 16'h8000, 24'h80_0000, 24'h0, 16'h0);
            endcase
         end
         fixed_next.push_back(rows[i].fixed);
         if (rows[i].fixed) fixed_vals.push_back(rows[i].result);
         send_word(rows[i].word);
      end

      foreach (pool[i]) pool[i] = {2'($urandom_range(0, 3)), 8'($urandom), 6'($urandom), 32'h0};
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         write_settings(pick16(), pick16(), pick24(24'h0), pick24(24'h1), pick16());
         if (ph == 1) hold_request = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 30 == 0) send_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) begin
               w = pool[$urandom_range(0, 7)];
            end else begin
               w.table_select = 2'($urandom_range(0, 3));
               w.first_index = 8'($urandom);
               w.second_index = 6'($urandom);
            end
            w.gradient = pick_gradient();
            send_word(w);
         end
      end

      wait_drained();
      $display("Checked %0d results: directed table, %0d random register settings,",
               checked, PHASES);
      $display("random stalls on both sides and one long result hold-off.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
